/* rtl/core/etrb_pkg.sv */
// shared types, constants and helpers of the eight-tap raster blur
package etrb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CH_W       = 8;
    localparam int COORD_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MIN_DIM    = 3;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 11'd1024;

    typedef logic [CH_W-1:0]    t_chan;
    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    // kinds of result one input can cause, in delivery order
    typedef enum logic [3:0] {
        RES_CENTER   = 4'b0001,
        RES_ROW_END  = 4'b0010,
        RES_LAST_ROW = 4'b0100,
        RES_CORNER   = 4'b1000
    } t_res_kind;

    typedef struct packed {
        logic [3:0] kinds;
        logic       interior;
        t_coord     row;
        t_coord     col;
    } t_meta;

    // width that holds any effective frame dimension and the raw register
    function automatic int dim_width(input int max_w, input int max_h);
        int m;
        int w;
        m = (max_w > max_h) ? max_w : max_h;
        w = $clog2(m + 1);
        return (w > CFG_DATA_W) ? w : CFG_DATA_W;
    endfunction

endpackage

/* rtl/core/etrb_pix_if.sv */
// pixel input channel
interface etrb_pix_if;
    logic          valid;
    logic          ready;
    etrb_pkg::t_chan in_red;
    etrb_pkg::t_chan in_green;
    etrb_pkg::t_chan in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue,
                  output ready);
endinterface

/* rtl/core/etrb_res_if.sv */
// result output channel
interface etrb_res_if;
    logic             valid;
    logic             ready;
    etrb_pkg::t_coord out_row;
    etrb_pkg::t_coord out_col;
    etrb_pkg::t_chan  out_red;
    etrb_pkg::t_chan  out_green;
    etrb_pkg::t_chan  out_blue;
    logic             run_last;
    logic             frame_done;

    modport source (output valid, output out_row, output out_col, output out_red,
                    output out_green, output out_blue, output run_last,
                    output frame_done, input ready);
    modport sink (input valid, input out_row, input out_col, input out_red,
                  input out_green, input out_blue, input run_last,
                  input frame_done, output ready);
endinterface

/* rtl/core/etrb_ram.sv */
// generic simple dual-port ram with registered read
module etrb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/etrb_fetch.sv */
// raster counters, line store access and first pipeline stage
module etrb_fetch #(
    parameter int MAX_WIDTH  = etrb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = etrb_pkg::MAX_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    etrb_pix_if.sink        i_pix,
    input  logic [etrb_pkg::dim_width(MAX_WIDTH, MAX_HEIGHT)-1:0] i_wlast,
    input  logic [etrb_pkg::dim_width(MAX_WIDTH, MAX_HEIGHT)-1:0] i_hlast,
    input  logic            i_take,
    output logic            o_valid,
    output etrb_pkg::t_meta o_meta,
    output etrb_pkg::t_pix  o_px,
    output etrb_pkg::t_pix  o_up,
    output etrb_pkg::t_pix  o_mid
);
    import etrb_pkg::*;

    localparam int DW = dim_width(MAX_WIDTH, MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = $bits(t_pix);

    logic [CW-1:0]   r_col, n_col, r_addr;
    logic [RW-1:0]   r_row, n_row;
    logic            r_valid;
    t_meta           r_meta, n_meta;
    t_pix            r_px;
    logic            accept, end_row, last_row, col_ge1, row_ge1, interior;
    logic [DW-1:0]   col_x, row_x;
    logic [2*PW-1:0] rd_data, wr_data;

    assign i_pix.ready = !r_valid || i_take;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        col_x    = DW'(r_col);
        row_x    = DW'(r_row);
        end_row  = col_x >= i_wlast;
        last_row = row_x >= i_hlast;
        col_ge1  = r_col != '0;
        row_ge1  = r_row != '0;
        interior = (row_x >= DW'(2)) && (row_x <= i_hlast)
                && (col_x >= DW'(2)) && (col_x <= i_wlast);

        n_meta.kinds = '0;
        if (row_ge1 && col_ge1) begin
            n_meta.kinds = n_meta.kinds | RES_CENTER;
        end
        if (row_ge1 && end_row) begin
            n_meta.kinds = n_meta.kinds | RES_ROW_END;
        end
        if (last_row && col_ge1) begin
            n_meta.kinds = n_meta.kinds | RES_LAST_ROW;
        end
        if (last_row && end_row) begin
            n_meta.kinds = n_meta.kinds | RES_CORNER;
        end
        n_meta.interior = interior;
        n_meta.row      = COORD_W'(r_row);
        n_meta.col      = COORD_W'(r_col);

        if (end_row) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_row   <= n_row;
            r_col   <= n_col;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meta <= n_meta;
            r_px   <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
            r_addr <= r_col;
        end
    end

    // entry holds {older row, newer row}; the newer one moves down on write
    assign wr_data = {rd_data[PW-1:0], r_px};

    etrb_ram #(
        .WIDTH (2 * PW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_valid && i_take),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (rd_data)
    );

    assign o_valid = r_valid;
    assign o_meta  = r_meta;
    assign o_px    = r_px;
    assign o_up    = t_pix'(rd_data[2*PW-1:PW]);
    assign o_mid   = t_pix'(rd_data[PW-1:0]);
endmodule

/* rtl/core/etrb_emit.sv */
// 3x3 window, result sequencing and output register
module etrb_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  etrb_pkg::t_meta i_meta,
    input  etrb_pkg::t_pix  i_px,
    input  etrb_pkg::t_pix  i_up,
    input  etrb_pkg::t_pix  i_mid,
    output logic            o_take,
    etrb_res_if.source      o_res
);
    import etrb_pkg::*;

    t_pix       r_win [3][3];
    logic       r_busy;
    t_meta      r_meta;
    logic [3:0] r_pend;
    logic [3:0] sel, rest;
    logic       fire, last_fire, take;

    logic       r_ovalid;
    t_coord     r_orow, r_ocol;
    t_pix       r_opx;
    logic       r_olast, r_odone;

    t_coord     n_orow, n_ocol;
    t_pix       n_opx, blur;
    logic       n_odone;

    function automatic t_chan avg8(input t_chan a, input t_chan b, input t_chan c,
                                   input t_chan d, input t_chan e, input t_chan f,
                                   input t_chan g, input t_chan h);
        logic [CH_W+2:0] s;
        s = (CH_W+3)'(a) + (CH_W+3)'(b) + (CH_W+3)'(c) + (CH_W+3)'(d)
          + (CH_W+3)'(e) + (CH_W+3)'(f) + (CH_W+3)'(g) + (CH_W+3)'(h);
        return s[CH_W+2:3];
    endfunction

    assign sel       = r_pend & (~r_pend + 4'd1);
    assign rest      = r_pend & ~sel;
    assign fire      = r_busy && (!r_ovalid || o_res.ready);
    assign last_fire = fire && (rest == '0);
    assign take      = i_valid && (!r_busy || last_fire);
    assign o_take    = take;

    // up-left tap left out
    always_comb begin
        blur.red   = avg8(r_win[0][1].red,   r_win[0][2].red,   r_win[1][0].red,
                          r_win[1][1].red,   r_win[1][2].red,   r_win[2][0].red,
                          r_win[2][1].red,   r_win[2][2].red);
        blur.green = avg8(r_win[0][1].green, r_win[0][2].green, r_win[1][0].green,
                          r_win[1][1].green, r_win[1][2].green, r_win[2][0].green,
                          r_win[2][1].green, r_win[2][2].green);
        blur.blue  = avg8(r_win[0][1].blue,  r_win[0][2].blue,  r_win[1][0].blue,
                          r_win[1][1].blue,  r_win[1][2].blue,  r_win[2][0].blue,
                          r_win[2][1].blue,  r_win[2][2].blue);
    end

    always_comb begin
        n_odone = 1'b0;
        case (t_res_kind'(sel))
            RES_CENTER: begin
                n_orow = r_meta.row - t_coord'(1);
                n_ocol = r_meta.col - t_coord'(1);
                n_opx  = r_meta.interior ? blur : r_win[1][1];
            end
            RES_ROW_END: begin
                n_orow = r_meta.row - t_coord'(1);
                n_ocol = r_meta.col;
                n_opx  = r_win[1][2];
            end
            RES_LAST_ROW: begin
                n_orow = r_meta.row;
                n_ocol = r_meta.col - t_coord'(1);
                n_opx  = r_win[2][1];
            end
            RES_CORNER: begin
                n_orow  = r_meta.row;
                n_ocol  = r_meta.col;
                n_opx   = r_win[2][2];
                n_odone = 1'b1;
            end
            default: begin
                n_orow = r_meta.row;
                n_ocol = r_meta.col;
                n_opx  = r_win[1][1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= '0;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_win[a][b] <= '0;
                end
            end
        end else if (take) begin
            r_busy <= i_meta.kinds != '0;
            r_pend <= i_meta.kinds;
            for (int a = 0; a < 3; a++) begin
                r_win[a][0] <= r_win[a][1];
                r_win[a][1] <= r_win[a][2];
            end
            r_win[0][2] <= i_up;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_px;
        end else if (fire) begin
            r_pend <= rest;
            if (last_fire) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_meta <= i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fire) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_orow  <= n_orow;
            r_ocol  <= n_ocol;
            r_opx   <= n_opx;
            r_olast <= rest == '0;
            r_odone <= n_odone;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.out_row    = r_orow;
    assign o_res.out_col    = r_ocol;
    assign o_res.out_red    = r_opx.red;
    assign o_res.out_green  = r_opx.green;
    assign o_res.out_blue   = r_opx.blue;
    assign o_res.run_last   = r_olast;
    assign o_res.frame_done = r_odone;
endmodule

/* rtl/core/eight_tap_raster_blur.sv */
// top level of the eight-tap raster blur
//
// pixels enter on i_pix in raster order, one beat per pixel, for a frame of
// frame_width x frame_height set through the write port (index 0 and 1,
// clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; write only while idle).
// results leave on o_res tagged with row and column; each input gives zero
// to four results, run_last marks the last one, frame_done the frame corner.
// one pixel per clock unless held as below: the line store ram is read
// when a pixel is accepted and written back when it moves into the window,
// never to the entry read at the same edge, so no interlock is needed.
// an input beat passes the fetch register, window and output register.
// an input that causes several results (row ends and the last row) holds
// the input side until its last result moves into the output register.
// when o_res stalls, the output register holds its beat, the window stage
// and the fetch stage fill, then i_pix.ready drops.
// reset clears the counters, window, pipeline valids and sets both
// dimensions to 1024; the line stores are not cleared and need no pass.
module eight_tap_raster_blur #(
    parameter int MAX_WIDTH  = etrb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = etrb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    etrb_pix_if.sink                           i_pix,
    etrb_res_if.source                         o_res,
    input  logic                               i_cfg_we,
    input  logic [etrb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [etrb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import etrb_pkg::*;

    localparam int DW = dim_width(MAX_WIDTH, MAX_HEIGHT);

    logic [DW-1:0] r_wlast, r_hlast;
    logic          s1_valid, take;
    t_meta         s1_meta;
    t_pix          s1_px, s1_up, s1_mid;

    // clamped dimension minus one
    function automatic logic [DW-1:0] last_index(input logic [CFG_DATA_W-1:0] v,
                                                 input int maxv);
        logic [DW-1:0] e;
        e = DW'(v);
        if (e < DW'(MIN_DIM)) begin
            e = DW'(MIN_DIM);
        end else if (e > DW'(maxv)) begin
            e = DW'(maxv);
        end
        return e - DW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= last_index(DIM_RESET, MAX_WIDTH);
            r_hlast <= last_index(DIM_RESET, MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_wlast <= last_index(i_cfg_data, MAX_WIDTH);
                CFG_FRAME_HEIGHT: r_hlast <= last_index(i_cfg_data, MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    etrb_fetch #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_wlast (r_wlast),
        .i_hlast (r_hlast),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_meta  (s1_meta),
        .o_px    (s1_px),
        .o_up    (s1_up),
        .o_mid   (s1_mid)
    );

    etrb_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_meta  (s1_meta),
        .i_px    (s1_px),
        .i_up    (s1_up),
        .i_mid   (s1_mid),
        .o_take  (take),
        .o_res   (o_res)
    );
endmodule

/* rtl/core/etrb_checker.sv */
// port-level checks of the eight-tap raster blur and their binding
module etrb_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input etrb_pkg::t_coord i_out_row,
    input etrb_pkg::t_coord i_out_col,
    input etrb_pkg::t_chan  i_out_red,
    input etrb_pkg::t_chan  i_out_green,
    input etrb_pkg::t_chan  i_out_blue,
    input logic             i_out_run_last,
    input logic             i_out_frame_done
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable({i_out_row, i_out_col,
            i_out_red, i_out_green, i_out_blue, i_out_run_last, i_out_frame_done}))
        else $error("stalled result beat changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_frame_done |-> i_out_run_last)
        else $error("frame corner beat not last of its run");

    // results of one input follow back to back, in the same or the next row
    a_run_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_run_last |=> i_out_valid
            && (i_out_row == $past(i_out_row) || i_out_row == $past(i_out_row) + 10'd1))
        else $error("broken result run");
endmodule

bind eight_tap_raster_blur etrb_checker u_etrb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_out_row        (o_res.out_row),
    .i_out_col        (o_res.out_col),
    .i_out_red        (o_res.out_red),
    .i_out_green      (o_res.out_green),
    .i_out_blue       (o_res.out_blue),
    .i_out_run_last   (o_res.run_last),
    .i_out_frame_done (o_res.frame_done)
);

/* test/tb_blur_pkg.sv */
// scoreboard and result record for the eight-tap raster blur testbench
package tb_blur_pkg;
    import etrb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int REPORT_CAP = 30;

    typedef struct packed {
        t_coord row;
        t_coord col;
        t_pix   pix;
        logic   run_last;
        logic   frame_done;
    } t_blur_res;

    class blur_scoreboard;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        t_pix older_row [MAX_WIDTH_DEF];
        t_pix newer_row [MAX_WIDTH_DEF];
        t_pix win [3][3];
        int unsigned row_at;
        int unsigned col_at;
        t_blur_res due [$];
        int unsigned fails;
        int unsigned checked;

        function new();
            int a;
            int b;
            width_reg = DIM_RESET;
            height_reg = DIM_RESET;
            for (a = 0; a < MAX_WIDTH_DEF; a++) begin
                older_row[a] = '0;
                newer_row[a] = '0;
            end
            for (a = 0; a < 3; a++) begin
                for (b = 0; b < 3; b++) begin
                    win[a][b] = '0;
                end
            end
            row_at = 0;
            col_at = 0;
            fails = 0;
            checked = 0;
        endfunction

        function int unsigned effective_dim(int unsigned raw, int unsigned max_dim);
            if (raw < MIN_DIM) return MIN_DIM;
            if (raw > max_dim) return max_dim;
            return raw;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FRAME_WIDTH) begin
                width_reg = data;
            end else if (idx == CFG_FRAME_HEIGHT) begin
                height_reg = data;
            end
        endfunction

        function int unsigned pending();
            return due.size();
        endfunction

        function bit at_origin();
            return (row_at == 0) && (col_at == 0);
        endfunction

        // sum of the window without the up-left tap, divided by eight
        function t_pix eight_tap_mean();
            int unsigned sum_r;
            int unsigned sum_g;
            int unsigned sum_b;
            int a;
            int b;
            t_pix m;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (a = 0; a < 3; a++) begin
                for (b = 0; b < 3; b++) begin
                    if (a != 0 || b != 0) begin
                        sum_r += win[a][b].red;
                        sum_g += win[a][b].green;
                        sum_b += win[a][b].blue;
                    end
                end
            end
            m.red = t_chan'(sum_r >> 3);
            m.green = t_chan'(sum_g >> 3);
            m.blue = t_chan'(sum_b >> 3);
            return m;
        endfunction

        function void add_result(t_coord row, t_coord col, t_pix px, logic done, logic last);
            t_blur_res rec;
            rec.row = row;
            rec.col = col;
            rec.pix = px;
            rec.run_last = last;
            rec.frame_done = done;
            due.push_back(rec);
        endfunction

        function void note_pixel(t_pix px);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            int unsigned idx;
            bit end_row;
            bit last_row;
            bit centre_out;
            bit tail_out;
            bit below_out;
            bit corner_out;
            bit interior;
            int n;
            int k;
            int a;
            t_pix v;
            w = effective_dim(width_reg, MAX_WIDTH_DEF);
            h = effective_dim(height_reg, MAX_HEIGHT_DEF);
            r = row_at;
            c = col_at;
            idx = c % MAX_WIDTH_DEF;
            end_row = (c >= w - 1);
            last_row = (r >= h - 1);

            for (a = 0; a < 3; a++) begin
                win[a][0] = win[a][1];
                win[a][1] = win[a][2];
            end
            win[0][2] = older_row[idx];
            win[1][2] = newer_row[idx];
            win[2][2] = px;
            older_row[idx] = newer_row[idx];
            newer_row[idx] = px;

            centre_out = (r >= 1) && (c >= 1);
            tail_out = (r >= 1) && end_row;
            below_out = last_row && (c >= 1);
            corner_out = last_row && end_row;
            n = int'(centre_out) + int'(tail_out) + int'(below_out) + int'(corner_out);
            k = 0;

            if (centre_out) begin
                interior = (r >= 2) && (r <= h - 1) && (c >= 2) && (c <= w - 1);
                v = interior ? eight_tap_mean() : win[1][1];
                k++;
                add_result(t_coord'(r - 1), t_coord'(c - 1), v, 1'b0, k == n);
            end
            if (tail_out) begin
                k++;
                add_result(t_coord'(r - 1), t_coord'(c), win[1][2], 1'b0, k == n);
            end
            if (below_out) begin
                k++;
                add_result(t_coord'(r), t_coord'(c - 1), win[2][1], 1'b0, k == n);
            end
            if (corner_out) begin
                k++;
                add_result(t_coord'(r), t_coord'(c), win[2][2], 1'b1, k == n);
            end

            if (end_row) begin
                col_at = 0;
                row_at = last_row ? 0 : r + 1;
            end else begin
                col_at = c + 1;
            end
        endfunction

        task report(string msg);
            fails++;
            if (fails <= REPORT_CAP) $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [9:0] got, logic [9:0] want, t_blur_res ctx);
            if (got !== want) begin
                report($sformatf("%s is %0h, want %0h, pixel (%0d,%0d)",
                                 name, got, want, ctx.row, ctx.col));
            end
        endtask

        task check_result(t_blur_res got);
            t_blur_res want;
            checked++;
            if (due.size() == 0) begin
                report($sformatf("beat for (%0d,%0d) with nothing pending", got.row, got.col));
            end else begin
                want = due.pop_front();
                compare_field("out_row", got.row, want.row, want);
                compare_field("out_col", got.col, want.col, want);
                compare_field("out_red", t_coord'(got.pix.red), t_coord'(want.pix.red), want);
                compare_field("out_green", t_coord'(got.pix.green), t_coord'(want.pix.green),
                              want);
                compare_field("out_blue", t_coord'(got.pix.blue), t_coord'(want.pix.blue),
                              want);
                compare_field("run_last", t_coord'(got.run_last), t_coord'(want.run_last),
                              want);
                compare_field("frame_done", t_coord'(got.frame_done),
                              t_coord'(want.frame_done), want);
            end
        endtask

        task finish_check();
            if (due.size() != 0) begin
                report($sformatf("%0d results never arrived, first (%0d,%0d)",
                                 due.size(), due[0].row, due[0].col));
            end
        endtask
    endclass

endpackage

/* test/tb_top.sv */
// testbench top of the eight-tap raster blur
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import etrb_pkg::*;
    import tb_blur_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 250;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    etrb_pix_if pix_ch ();
    etrb_res_if res_ch ();

    blur_scoreboard sb;
    t_blur_res      res_beat;
    bit             steady_feed = 1'b0;
    int unsigned    pixel_total = 0;
    int unsigned    frame_total = 0;
    int             idle_cycles = 0;

    eight_tap_raster_blur dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic t_pix random_pix();
        t_pix p;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        p.red = t_chan'($urandom_range(0, 255));
        p.green = t_chan'($urandom_range(0, 255));
        p.blue = t_chan'($urandom_range(0, 255));
        if (roll == 0) begin
            p.green = 8'h00;
            p.blue = 8'h00;
        end else if (roll == 1) begin
            p.red = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            p.green = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            p.blue = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end
        return p;
    endfunction

    task automatic send_pixel(input t_pix px);
        int unsigned gap;
        gap = steady_feed ? 0 : pick_gap();
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.in_red <= px.red;
        pix_ch.in_green <= px.green;
        pix_ch.in_blue <= px.blue;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
        sb.note_pixel(px);
        pixel_total++;
    endtask

    // wait for every pending result plus the pipeline tail
    task automatic settle();
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w_raw,
                             input logic [CFG_DATA_W-1:0] h_raw, input bit spare);
        logic [CFG_IDX_W-1:0]  spare_idx;
        logic [CFG_DATA_W-1:0] spare_val;
        cfg_we <= 1'b1;
        cfg_idx <= CFG_FRAME_WIDTH;
        cfg_data <= w_raw;
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_WIDTH, w_raw);
        cfg_idx <= CFG_FRAME_HEIGHT;
        cfg_data <= h_raw;
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_HEIGHT, h_raw);
        if (spare) begin
            spare_idx = ($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO;
            spare_val = CFG_DATA_W'($urandom_range(0, 2047));
            cfg_idx <= spare_idx;
            cfg_data <= spare_val;
            @(posedge i_clk);
            sb.write_reg(spare_idx, spare_val);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_frame(input logic [CFG_DATA_W-1:0] w_raw,
                             input logic [CFG_DATA_W-1:0] h_raw,
                             input bit reshape, input bit spare);
        int unsigned cut;
        int unsigned sent;
        settle();
        set_frame(w_raw, h_raw, spare);
        steady_feed = ($urandom_range(0, 3) == 0);
        cut = $urandom_range(1, 20);
        sent = 0;
        do begin
            // dimensions change between two beats of the same frame
            if (reshape && sent == cut) begin
                settle();
                set_frame(CFG_DATA_W'($urandom_range(3, 12)),
                          CFG_DATA_W'($urandom_range(3, 8)), 1'b0);
            end
            send_pixel(random_pix());
            sent++;
        end while (!sb.at_origin());
        frame_total++;
    endtask

    initial begin
        int unsigned burst;
        int unsigned stall;
        res_ch.ready <= 1'b1;
        forever begin
            burst = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(40, 200);
            repeat (burst) @(posedge i_clk);
            stall = pick_gap();
            if (stall != 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            res_beat.row = res_ch.out_row;
            res_beat.col = res_ch.out_col;
            res_beat.pix.red = res_ch.out_red;
            res_beat.pix.green = res_ch.out_green;
            res_beat.pix.blue = res_ch.out_blue;
            res_beat.run_last = res_ch.run_last;
            res_beat.frame_done = res_ch.frame_done;
            sb.check_result(res_beat);
        end
    end

    always @(posedge i_clk) begin
        if ((pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned k;
        int unsigned rand_start;
        int unsigned roll;
        logic [CFG_DATA_W-1:0] w_raw;
        logic [CFG_DATA_W-1:0] h_raw;
        bit tall;
        t_pix px;

        sb = new();
        i_rst_n <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.in_red <= '0;
        pix_ch.in_green <= '0;
        pix_ch.in_blue <= '0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_FRAME_WIDTH;
        cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // dimensions below the minimum, full-scale red, alternating blue
        settle();
        set_frame(11'd0, 11'd2, 1'b1);
        for (k = 0; k < 9; k++) begin
            px.red = 8'hFF;
            px.green = 8'h00;
            px.blue = (k % 2 != 0) ? 8'hAA : 8'h55;
            send_pixel(px);
        end
        frame_total++;

        // red ramp frame, green and blue zero, dimensions below the minimum
        settle();
        set_frame(11'd1, 11'd0, 1'b0);
        for (k = 0; k < 9; k++) begin
            px.red = t_chan'(k * 29 + 3);
            px.green = 8'h00;
            px.blue = 8'h00;
            send_pixel(px);
        end
        frame_total++;

        // twelve-wide frame fills line store columns 0 to 11 before the later frames
        run_frame(11'd12, 11'd3, 1'b0, 1'b0);

        // width register above the maximum, narrowed after the first beats
        run_frame(11'd1025, 11'd3, 1'b1, 1'b1);

        rand_start = pixel_total;
        while (pixel_total - rand_start < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            w_raw = (roll < 10) ? CFG_DATA_W'($urandom_range(0, 2))
                                : CFG_DATA_W'($urandom_range(3, 12));
            roll = $urandom_range(0, 99);
            tall = (pixel_total == rand_start) || (roll < 8);
            if (tall) begin
                h_raw = CFG_DATA_W'($urandom_range(1024, 2047));
            end else begin
                h_raw = (roll < 18) ? CFG_DATA_W'($urandom_range(0, 2))
                                    : CFG_DATA_W'($urandom_range(3, 8));
            end
            run_frame(w_raw, h_raw, tall || ($urandom_range(0, 4) == 0),
                      $urandom_range(0, 3) == 0);
        end

        settle();
        sb.finish_check();
        $display("covered %0d pixels in %0d frames: clamped, over-wide, tall and reshaped",
                 pixel_total, frame_total);
        $display("%0d result beats checked, %0d mismatches", sb.checked, sb.fails);
        if (sb.fails == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
